[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/itrd_pkg.sv]
// ---------------------------------------------------------------------------
// itrd_pkg
// Shared constants and helpers of the radix digit converter.
// ---------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int MAX_DIGITS_DEF  = 32;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;  // 'A'
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_NONE = 7'h00;

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Clamp the programmed base into 2..16.
  function automatic radix_t eff_radix(input radix_t r);
    radix_t res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic char_t digit_to_ascii(input digit_t d);
    char_t res;
    if (d < DEC_LIMIT) begin
      res = CHAR_ZERO + char_t'(d);
    end else begin
      res = CHAR_A + char_t'(d - DEC_LIMIT);
    end
    return res;
  endfunction

endpackage

[rtl/core/itrd_in_if.sv]
// ---------------------------------------------------------------------------
// itrd_in_if
// Input channel: one integer per item, valid/ready handshake.
// ---------------------------------------------------------------------------
interface itrd_in_if #(
  parameter int VALUE_WIDTH = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/itrd_out_if.sv]
// ---------------------------------------------------------------------------
// itrd_out_if
// Result channel: one ASCII digit or a no_digits marker per item, valid/ready handshake.
// ---------------------------------------------------------------------------
interface itrd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       is_last;
  logic       no_digits;

  modport source (output valid, output digit_char, output is_last, output no_digits,
                  input ready);
  modport sink   (input valid, input digit_char, input is_last, input no_digits,
                  output ready);
endinterface

[rtl/core/itrd_ram.sv]
// ---------------------------------------------------------------------------
// itrd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module itrd_ram #(
  parameter  int WIDTH  = 4,
  parameter  int DEPTH  = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/itrd_divider.sv]
// ---------------------------------------------------------------------------
// itrd_divider
// Restoring divider, one quotient bit per cycle, divisor 2..16.
// ---------------------------------------------------------------------------
module itrd_divider
  import itrd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  radix_t                 divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output digit_t                 remainder
);

  localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] dvd_r, dvd_nxt;
  digit_t                 rem_r, rem_nxt;
  logic [RADIX_W-1:0]     trial;
  logic                   fits;

  // Partial remainder stays below the divisor, so 4 bits plus the next bit do.
  assign trial = {rem_r, dvd_r[VALUE_WIDTH-1]};
  assign fits  = trial >= divisor;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[VALUE_WIDTH-2:0], fits};
      rem_nxt = fits ? DIGIT_W'(trial - divisor) : trial[DIGIT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

[rtl/core/integer_to_radix_digits_top.sv]
// ---------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a non-negative integer into ASCII digits of a programmable base.
// ---------------------------------------------------------------------------
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-------------------------------------
//   in_ch    | in  | valid / ready     | value [VALUE_WIDTH-1:0]
//   out_ch   | out | valid / ready     | digit_char[6:0], is_last, no_digits
//   cfg      | in  | cfg_we            | cfg_wdata[4:0] = radix
//
// One item at a time. Each digit comes from one pass of the bit-serial
// divider, then the digit store is read back with one read in flight at a
// time. A zero value gives one no_digits result. Reset (rst_n, sync) clears
// control and sets radix to 16; the digit store needs no clearing. A stalled
// out_ch holds digit readout and the no_digits result only.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_radix_digits_top
  import itrd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  itrd_in_if.sink       in_ch,
  itrd_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_wdata
);

  localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DIGITS - 1);

  // Control states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] S_ZERO = 2'd1;  // zero value, post the no_digits result
  localparam logic [1:0] S_DIV  = 2'd2;  // dividing, remainders go to the store
  localparam logic [1:0] S_EMIT = 2'd3;  // reading digits back, MS first

  logic [1:0]        state_r, state_nxt;
  radix_t            radix_r;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_last_r, rd_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  char_t             out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_nod_r, out_nod_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  digit_t                 div_rem;
  logic                   div_stop;
  logic                   ram_we;
  logic                   rd_issue;
  digit_t                 ram_rdata;

  // -------------------------------------------------------------------------
  // Radix register; the clamp to 2..16 is applied on use.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // -------------------------------------------------------------------------
  // Divider: first pass takes the input, later passes chain the quotient.
  // -------------------------------------------------------------------------
  assign div_stop     = (div_quot == '0) || (wr_addr_r == LAST_ADDR);
  assign div_start    = (in_acc && (in_ch.value != '0)) ||
                        ((state_r == S_DIV) && div_done && !div_stop);
  assign div_dividend = (state_r == S_IDLE) ? in_ch.value : div_quot;

  itrd_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (eff_radix(radix_r)),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // -------------------------------------------------------------------------
  // Digit store. Writes happen only while dividing and reads only while
  // emitting, so the same entry is never written and read in one cycle.
  // -------------------------------------------------------------------------
  assign ram_we   = (state_r == S_DIV) && div_done;
  assign rd_issue = (state_r == S_EMIT) && !rd_pend_r && out_free;

  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (div_rem),
    .re    (rd_issue),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // -------------------------------------------------------------------------
  // Sequencer and output register
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    wr_addr_nxt   = wr_addr_r;
    rd_addr_nxt   = rd_addr_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_nod_nxt   = out_nod_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wr_addr_nxt = '0;
          state_nxt   = (in_ch.value == '0) ? S_ZERO : S_DIV;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_NONE;
          out_last_nxt  = 1'b1;
          out_nod_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_addr_nxt = wr_addr_r + 1'b1;
          if (div_stop) begin
            rd_addr_nxt = wr_addr_r;
            state_nxt   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (rd_issue) begin
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (rd_addr_r == '0);
          rd_addr_nxt = rd_addr_r - 1'b1;
        end
        // Read data lands in the cycle after issue; the output slot is free then.
        if (rd_pend_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(ram_rdata);
          out_last_nxt  = rd_last_r;
          out_nod_nxt   = 1'b0;
          if (rd_last_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wr_addr_r  <= wr_addr_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_last_r  <= rd_last_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_nod_r  <= out_nod_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.is_last    = out_last_r;
  assign out_ch.no_digits  = out_nod_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_IMPL(a_rd_slot_free, clk, rst_n, rd_pend_r, !out_valid_r, "read data with output slot full")
  `ASSERT_NEXT(a_acc_leaves_idle, clk, rst_n, in_acc, (state_r == S_ZERO) || (state_r == S_DIV), "accepted item did not start")
  `ASSERT_NEXT(a_last_to_idle, clk, rst_n, rd_pend_r && rd_last_r, state_r == S_IDLE, "last digit did not end item")

endmodule

[dv/integer_to_radix_digits_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_to_radix_digits_top_tb
// Self-checking bench for the radix digit converter. Integers go in on the
// input channel, and every digit item that comes out is checked against a
// predictor of the repeated division by the programmed base. The run starts
// with a short directed part and then moves on to random phases, each with
// a new base and, save in the final phases, random gaps on both channels.
// ---------------------------------------------------------------------------
module integer_to_radix_digits_top_tb;
  import itrd_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int NDIG = MAX_DIGITS_DEF;
  localparam int RANDOM_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 30;

  typedef struct packed {
    char_t digit_char;
    logic  is_last;
    logic  no_digits;
  } digit_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  itrd_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  itrd_out_if out_ch ();

  integer_to_radix_digits_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [VW-1:0] values_to_send[$];  // integers waiting for the driver
  digit_item_t   pending_digits[$];  // digits predicted, not yet seen
  radix_t        radix_shadow;       // base as last written to the block
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatches;

  // Predict the digit items of one accepted integer: divide down by the
  // clamped base, remainders land LSD first, then emit them MSD first.
  function automatic void predict_digits(input logic [VW-1:0] value);
    digit_t        remainders[NDIG];
    logic [VW-1:0] quot;
    radix_t        base;
    int            count;
    digit_t        d;
    digit_item_t   item;
    // bases below two or above sixteen saturate
    if (radix_shadow < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_shadow > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_shadow;
    end
    // zero: one item flagged as having no digits
    if (value == '0) begin
      item.digit_char = CHAR_NONE;
      item.is_last    = 1'b1;
      item.no_digits  = 1'b1;
      pending_digits.push_back(item);
      return;
    end
    quot  = value;
    count = 0;
    while (quot != '0 && count < NDIG) begin
      remainders[count] = digit_t'(quot % base);
      quot  = quot / base;
      count = count + 1;
    end
    for (int i = count - 1; i >= 0; i--) begin
      d = remainders[i];
      if (d < DEC_LIMIT) begin
        item.digit_char = CHAR_ZERO + char_t'(d);
      end else begin
        item.digit_char = CHAR_A + char_t'(d - DEC_LIMIT);
      end
      item.is_last   = (i == 0);
      item.no_digits = 1'b0;
      pending_digits.push_back(item);
    end
  endfunction

  // Driver: presents queued integers, with random gaps between items.
  always @(posedge clk) begin : drive_values
    logic holding;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
    end else begin
      holding = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value);
        holding = 1'b0;
      end
      // only touch valid when the current item is gone, so it never dips
      if (!holding) begin
        if (values_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= values_to_send.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted digit item against the oldest prediction,
  // and throttles ready at random.
  always @(posedge clk) begin : check_digits
    digit_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_digits.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none, actual char %h last %b none %b",
                   $realtime, out_ch.digit_char, out_ch.is_last, out_ch.no_digits);
        end else begin
          want = pending_digits.pop_front();
          if (out_ch.digit_char !== want.digit_char) begin
            mismatches++;
            $display("%0t: digit_char expected %h actual %h",
                     $realtime, want.digit_char, out_ch.digit_char);
          end
          if (out_ch.is_last !== want.is_last) begin
            mismatches++;
            $display("%0t: is_last expected %b actual %b",
                     $realtime, want.is_last, out_ch.is_last);
          end
          if (out_ch.no_digits !== want.no_digits) begin
            mismatches++;
            $display("%0t: no_digits expected %b actual %b",
                     $realtime, want.no_digits, out_ch.no_digits);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Wait until every integer is sent and every digit has come back, then
  // let the block settle into idle.
  task automatic drain();
    do @(negedge clk);
    while (values_to_send.size() != 0 || in_ch.valid || pending_digits.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Base changes only while the block is idle.
  task automatic write_radix(input radix_t r);
    drain();
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= r;
    radix_shadow  = r;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of shapes: zeros, short and long numbers, single bits, near-max and
  // full-range values so every input bit toggles.
  function automatic logic [VW-1:0] random_value();
    logic [VW-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1, 2:    v = VW'($urandom_range(1, 255));
      3:       v = VW'($urandom_range(256, 65535));
      4:       v = {VW{1'b1}} - VW'($urandom_range(0, 1000));
      5:       v = VW'(1) << $urandom_range(0, VW - 1);
      default: v = VW'($urandom());
    endcase
    return v;
  endfunction

  initial begin : stimulus
    radix_t r;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    radix_shadow  = RADIX_RESET;
    mismatches    = 0;
    send_idle_pct = 20;
    recv_idle_pct = 64;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, bases at both ends, saturation of the base.
    write_radix(5'd16);
    values_to_send.push_back(31'd0);           // zero: no digits
    values_to_send.push_back(31'd1);
    values_to_send.push_back(31'd15);          // largest single hex digit
    values_to_send.push_back(31'd16);
    values_to_send.push_back(31'h7FFFFFFF);    // full-scale value
    values_to_send.push_back(31'h40000000);
    values_to_send.push_back(31'h2AAAAAAA);
    values_to_send.push_back(31'h55555555);
    write_radix(5'd2);
    values_to_send.push_back(31'd1);
    values_to_send.push_back(31'd2);
    values_to_send.push_back(31'h7FFFFFFF);    // 31 digits, the longest item
    values_to_send.push_back(31'd0);
    write_radix(5'd10);
    values_to_send.push_back(31'd9);
    values_to_send.push_back(31'd10);
    values_to_send.push_back(31'd2147483647);
    values_to_send.push_back(31'd1000000000);
    write_radix(5'd0);                         // below two: acts as base 2
    values_to_send.push_back(31'd5);
    write_radix(5'd1);
    values_to_send.push_back(31'd6);
    write_radix(5'd17);                        // above sixteen: acts as base 16
    values_to_send.push_back(31'd255);
    write_radix(5'd31);
    values_to_send.push_back(31'h7FFFFFFF);
    write_radix(5'd3);
    values_to_send.push_back(31'h7FFFFFFF);

    // Random phases; gap profile flips after a third of them, then no gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 20;
      end else if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0:       r = 5'd2;
        1:       r = 5'd16;
        default: r = radix_t'($urandom_range(0, 31));
      endcase
      write_radix(r);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        values_to_send.push_back(random_value());
      end
    end

    drain();
    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #16_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[integer_to_radix_digits_top.f]
+incdir+rtl/core
rtl/core/itrd_pkg.sv
rtl/core/itrd_in_if.sv
rtl/core/itrd_out_if.sv
rtl/core/itrd_ram.sv
rtl/core/itrd_divider.sv
rtl/core/integer_to_radix_digits_top.sv
dv/integer_to_radix_digits_top_tb.sv
